// File: rtl/gmts_pkg.sv
// Package with the shared types, widths and constants of the travel sequencer.
`default_nettype none

package gmts_pkg;

    // Fraction bits of the eased angle; the smoothing rate is always Q16.
    localparam int FRAC_BITS   = 16;
    localparam int RATE_BITS   = 16;
    localparam int COUNT_W     = 13;
    localparam int ANGLE_W     = FRAC_BITS + COUNT_W;
    localparam int BIAS_W      = 14;
    localparam int OFFSET_W    = 13;
    localparam int WAIT_W      = 11;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // Limits on the travel target and the dwell length.
    localparam logic [COUNT_W-1:0] TRAVEL_MIN   = COUNT_W'(32);
    localparam logic [COUNT_W-1:0] TRAVEL_MAX   = COUNT_W'(4096);
    localparam logic [WAIT_W-1:0]  WAIT_MAX     = WAIT_W'(2046);
    localparam logic [COUNT_W-1:0] END_LIMIT    = COUNT_W'(15);
    localparam logic [COUNT_W-1:0] NEAR_MARGIN  = COUNT_W'(16);

    // Register reset values.
    localparam logic [OFFSET_W-1:0]  OFFSET_RESET = '0;
    localparam logic [RATE_BITS-1:0] RATE_RESET   = RATE_BITS'(655);
    localparam logic [WAIT_W-1:0]    WAIT_RESET   = WAIT_W'(1000);
    localparam logic [COUNT_W-1:0]   TRAVEL_RESET = COUNT_W'(4096);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ANGLE_OFFSET   = 2'd0,
        CFG_SMOOTHING_RATE = 2'd1,
        CFG_WAIT_TICKS     = 2'd2,
        CFG_TRAVEL_ANGLE   = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        PH_OFF   = 2'd0,
        PH_START = 2'd1,
        PH_WAIT  = 2'd2,
        PH_END   = 2'd3
    } t_phase;

    // Configuration as the datapath sees it, limits already applied.
    typedef struct packed {
        logic [OFFSET_W-1:0]  angle_offset;
        logic [RATE_BITS-1:0] smoothing_rate;
        logic [WAIT_W-1:0]    wait_limit;
        logic [COUNT_W-1:0]   travel;
    } t_cfg;

    typedef struct packed {
        logic [BIAS_W-1:0] motor_bias;
        t_phase            phase;
        logic              locked;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/gmts_if.sv
// Stream interfaces for the sensor beats and the result beats.
`default_nettype none

interface gmts_sensor_if;
    logic valid;
    logic ready;
    logic sensor_a;
    logic sensor_b;

    modport source (output valid, output sensor_a, output sensor_b, input ready);
    modport sink   (input valid, input sensor_a, input sensor_b, output ready);
endinterface

interface gmts_result_if import gmts_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BIAS_W-1:0] motor_bias;
    logic [1:0]        phase;
    logic              locked;

    modport source (output valid, output motor_bias, output phase, output locked, input ready);
    modport sink   (input valid, input motor_bias, input phase, input locked, output ready);
endinterface

`default_nettype wire

// File: rtl/gated_motor_travel_sequencer.sv
// Top level of the gated motor travel sequencer: beat registers and submodules.
//
// One sensor beat is one control tick and yields one result beat. A new beat
// is taken every clock cycle while results drain; each passes an input register
// and then the result register, from which its result is offered as valid.
// The rate is set by the state update of one tick, a single 30 x 17 bit
// multiply of the exponential filter plus compares, all combinational.
// A stalled result holds its register and the input register; a further beat
// is accepted only when the input register can move on. Configuration writes
// take effect from the next clock edge and are to be made while idle.
`default_nettype none

module gated_motor_travel_sequencer import gmts_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    gmts_sensor_if.sink                 i_sensor,
    gmts_result_if.source               o_result
);

    logic    r_in_valid;
    logic    r_sensor_a;
    logic    r_sensor_b;
    logic    r_out_valid;
    t_result r_out;

    logic    advance;
    logic    in_take;
    t_cfg    cfg;
    t_result step_result;

    // The input register moves on when the result register is free or drains.
    assign advance        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_sensor.ready = !r_in_valid || advance;
    assign in_take        = i_sensor.valid && i_sensor.ready;

    gmts_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    gmts_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_sensor_a (r_sensor_a),
        .i_sensor_b (r_sensor_b),
        .i_cfg      (cfg),
        .o_result   (step_result)
    );

    // Input beat register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_sensor_a <= i_sensor.sensor_a;
            r_sensor_b <= i_sensor.sensor_b;
        end
    end

    // Result beat register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.motor_bias = r_out.motor_bias;
    assign o_result.phase      = r_out.phase;
    assign o_result.locked     = r_out.locked;

    // A waiting result is never overwritten or dropped.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result lost");

    // A beat is never taken into a full input register that cannot move on.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_take && r_in_valid && !advance))
        else $error("input register overrun");

    // Every advance yields a result beat in the next cycle.
    a_advance_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advance without result");

endmodule

`default_nettype wire

// File: rtl/gmts_cfg_regs.sv
// Configuration registers with the range limits applied on their outputs.
`default_nettype none

module gmts_cfg_regs import gmts_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                        o_cfg
);

    logic [OFFSET_W-1:0]  r_offset;
    logic [RATE_BITS-1:0] r_rate;
    logic [WAIT_W-1:0]    r_wait;
    logic [COUNT_W-1:0]   r_travel;

    // Register writes, one register per write beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OFFSET_RESET;
            r_rate   <= RATE_RESET;
            r_wait   <= WAIT_RESET;
            r_travel <= TRAVEL_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ANGLE_OFFSET:   r_offset <= i_cfg_data[OFFSET_W-1:0];
                CFG_SMOOTHING_RATE: r_rate   <= i_cfg_data[RATE_BITS-1:0];
                CFG_WAIT_TICKS:     r_wait   <= i_cfg_data[WAIT_W-1:0];
                CFG_TRAVEL_ANGLE:   r_travel <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp the travel target and the dwell length into their working ranges.
    always_comb begin
        o_cfg.angle_offset   = r_offset;
        o_cfg.smoothing_rate = r_rate;
        o_cfg.wait_limit     = (r_wait > WAIT_MAX) ? WAIT_MAX : r_wait;
        if (r_travel < TRAVEL_MIN) begin
            o_cfg.travel = TRAVEL_MIN;
        end else if (r_travel > TRAVEL_MAX) begin
            o_cfg.travel = TRAVEL_MAX;
        end else begin
            o_cfg.travel = r_travel;
        end
    end

endmodule

`default_nettype wire

// File: rtl/gmts_step.sv
// Sequencer state and the per-tick update: filter step, dwell count and phase.
`default_nettype none

module gmts_step import gmts_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_advance,
    input  wire logic i_sensor_a,
    input  wire logic i_sensor_b,
    input  t_cfg      i_cfg,
    output t_result   o_result
);

    localparam int DIFF_W = ANGLE_W + 1;
    localparam int PROD_W = DIFF_W + RATE_BITS + 1;
    localparam logic [ANGLE_W-1:0] MAX_ANGLE = {TRAVEL_MAX, {FRAC_BITS{1'b0}}};

    logic [ANGLE_W-1:0] r_eased, n_eased;
    t_phase             r_phase, n_phase;
    logic               r_lock, n_lock;
    logic [WAIT_W-1:0]  r_dwell, n_dwell;

    logic                      both_off;
    logic                      both_on;
    logic [ANGLE_W-1:0]        target;
    logic [ANGLE_W-1:0]        angle0;
    logic [ANGLE_W-1:0]        ease_goal;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  step_sh;
    logic [ANGLE_W-1:0]        eased_next;
    logic [WAIT_W-1:0]         dwell0;
    logic [WAIT_W-1:0]         dwell_inc;
    logic [BIAS_W-1:0]         bias;

    assign both_off = !i_sensor_a && !i_sensor_b;
    assign both_on  = i_sensor_a && i_sensor_b;
    assign target   = {i_cfg.travel, {FRAC_BITS{1'b0}}};

    // Leaving both barriers clears the angle before the phase work.
    assign angle0 = both_off ? '0 : r_eased;

    // Filter step written as a + ((goal - a) * r >>> 16), one multiplier.
    assign ease_goal  = (r_phase == PH_END) ? '0 : target;
    assign diff       = $signed({1'b0, ease_goal}) - $signed({1'b0, angle0});
    assign prod       = PROD_W'(diff) * $signed({1'b0, i_cfg.smoothing_rate});
    assign step_sh    = prod >>> RATE_BITS;
    assign eased_next = angle0 + step_sh[ANGLE_W-1:0];

    // Dwell counter preset on leaving in mid-cycle.
    always_comb begin
        dwell0 = r_dwell;
        if (both_off && (r_phase == PH_START || r_phase == PH_WAIT)) begin
            dwell0 = i_cfg.wait_limit;
        end
    end
    assign dwell_inc = dwell0 + WAIT_W'(1);

    // Next state of angle, counter and phase for one tick.
    always_comb begin
        n_eased = angle0;
        n_dwell = dwell0;
        n_phase = r_phase;
        n_lock  = both_off ? 1'b0 : r_lock;
        case (r_phase)
            PH_END: begin
                n_eased = eased_next;
                if (eased_next < {END_LIMIT, {FRAC_BITS{1'b0}}}) begin
                    n_phase = PH_OFF;
                end
            end
            PH_WAIT: begin
                n_eased = target;
                n_dwell = dwell_inc;
                if (dwell_inc > i_cfg.wait_limit) begin
                    n_dwell = '0;
                    n_phase = PH_END;
                end
            end
            PH_START: begin
                n_eased = eased_next;
                if (eased_next > {i_cfg.travel - NEAR_MARGIN, {FRAC_BITS{1'b0}}}) begin
                    n_phase = PH_WAIT;
                end
            end
            default: begin
            end
        endcase
        if (both_on && n_phase == PH_OFF && !n_lock) begin
            n_phase = PH_START;
            n_lock  = 1'b1;
        end
    end

    // Result of this tick, taken from the updated state.
    assign bias = BIAS_W'(i_cfg.angle_offset) + BIAS_W'(n_eased[ANGLE_W-1:FRAC_BITS]);

    always_comb begin
        o_result.motor_bias = bias;
        o_result.phase      = n_phase;
        o_result.locked     = n_lock;
    end

    // State registers advance once per sensor beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eased <= '0;
            r_phase <= PH_OFF;
            r_lock  <= 1'b0;
            r_dwell <= '0;
        end else if (i_advance) begin
            r_eased <= n_eased;
            r_phase <= n_phase;
            r_lock  <= n_lock;
            r_dwell <= n_dwell;
        end
    end

    // The angle never passes the largest travel target.
    a_angle_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eased <= MAX_ANGLE)
        else $error("eased angle beyond travel range");

    // Both barriers on while idle and unlocked starts a locked cycle.
    a_start_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && both_on && r_phase == PH_OFF && !r_lock)
        |=> (r_phase == PH_START && r_lock))
        else $error("cycle did not start");

    // Both barriers off while idle clears the angle and unlocks.
    a_leave_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && both_off && r_phase == PH_OFF) |=> (r_eased == '0 && !r_lock))
        else $error("leaving did not clear state");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench of the gated motor travel sequencer, with its own tick predictor.
`default_nettype none

module tb_top import gmts_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 4;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   cfg_we;
    t_cfg_index             cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    gmts_sensor_if sensor_bus ();
    gmts_result_if result_bus ();

    gated_motor_travel_sequencer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_sensor    (sensor_bus),
        .o_result    (result_bus)
    );

    // Free-running 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Register copies as the predictor sees them.
    logic [OFFSET_W-1:0]  cfg_offset = OFFSET_RESET;
    logic [RATE_BITS-1:0] cfg_rate   = RATE_RESET;
    logic [WAIT_W-1:0]    cfg_wait   = WAIT_RESET;
    logic [COUNT_W-1:0]   cfg_travel = TRAVEL_RESET;

    // Predicted sequencer state.
    logic [63:0]          mdl_angle = '0;
    t_phase               mdl_phase = PH_OFF;
    logic                 mdl_lock  = 1'b0;
    logic [WAIT_W-1:0]    mdl_dwell = '0;

    t_result expected_ticks[$];

    int errors;
    int beats_sent;
    int beats_checked;
    int cycles_done;
    int settings_applied;
    bit tx_idle_on;
    bit rx_idle_on;
    int rx_hold_req;

    // One exponential filter step in Q16 rate, truncating.
    function automatic logic [63:0] ease_step(logic [63:0] angle, logic [63:0] goal);
        logic [63:0] r;
        r = 64'(cfg_rate);
        return (angle * (64'd65536 - r) + goal * r) >> 16;
    endfunction

    // Advance the predicted state by one tick and return the expected result beat.
    function automatic t_result step_travel(logic a, logic b);
        logic [63:0]       t;
        logic [63:0]       goal;
        logic [WAIT_W-1:0] w;
        t_result           beat;
        t = 64'(cfg_travel);
        if (t < 64'(TRAVEL_MIN)) t = 64'(TRAVEL_MIN);
        if (t > 64'(TRAVEL_MAX)) t = 64'(TRAVEL_MAX);
        goal = t << FRAC_BITS;
        w = cfg_wait;
        if (w > WAIT_MAX) w = WAIT_MAX;

        // Both barriers off clears the angle and the lock.
        if (!a && !b) begin
            mdl_angle = '0;
            mdl_lock  = 1'b0;
            if (mdl_phase == PH_START || mdl_phase == PH_WAIT) mdl_dwell = w;
        end

        case (mdl_phase)
            PH_END: begin
                mdl_angle = ease_step(mdl_angle, '0);
                if (mdl_angle < (64'(END_LIMIT) << FRAC_BITS)) begin
                    mdl_phase = PH_OFF;
                    cycles_done++;
                end
            end
            PH_WAIT: begin
                mdl_angle = goal;
                mdl_dwell = mdl_dwell + 1'b1;
                if (mdl_dwell > w) begin
                    mdl_dwell = '0;
                    mdl_phase = PH_END;
                end
            end
            PH_START: begin
                mdl_angle = ease_step(mdl_angle, goal);
                if (mdl_angle > ((t - 64'(NEAR_MARGIN)) << FRAC_BITS)) mdl_phase = PH_WAIT;
            end
            default: ;
        endcase

        // A new cycle starts only from off and unlocked.
        if (a && b && mdl_phase == PH_OFF && !mdl_lock) begin
            mdl_phase = PH_START;
            mdl_lock  = 1'b1;
        end

        beat.motor_bias = BIAS_W'(64'(cfg_offset) + (mdl_angle >> FRAC_BITS));
        beat.phase      = mdl_phase;
        beat.locked     = mdl_lock;
        return beat;
    endfunction

    // Offer one sensor beat, with an optional random gap first, and predict it once taken.
    task automatic send_tick(logic a, logic b);
        int gap;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
            sensor_bus.valid    <= 1'b0;
            sensor_bus.sensor_a <= 1'($urandom_range(0, 1));
            sensor_bus.sensor_b <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge i_clk);
        end
        sensor_bus.valid    <= 1'b1;
        sensor_bus.sensor_a <= a;
        sensor_bus.sensor_b <= b;
        do @(posedge i_clk); while (!sensor_bus.ready);
        expected_ticks.push_back(step_travel(a, b));
        beats_sent++;
    endtask

    // Stop offering and wait until every predicted result beat has come back.
    task automatic drain_pipeline();
        sensor_bus.valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers back to back while the block is idle.
    task automatic apply_config(logic [15:0] offset, logic [15:0] rate,
                                logic [15:0] dwell, logic [15:0] travel);
        drain_pipeline();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ANGLE_OFFSET;
        cfg_data  <= offset;
        @(posedge i_clk);
        cfg_index <= CFG_SMOOTHING_RATE;
        cfg_data  <= rate;
        @(posedge i_clk);
        cfg_index <= CFG_WAIT_TICKS;
        cfg_data  <= dwell;
        @(posedge i_clk);
        cfg_index <= CFG_TRAVEL_ANGLE;
        cfg_data  <= travel;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        cfg_offset = offset[OFFSET_W-1:0];
        cfg_rate   = rate[RATE_BITS-1:0];
        cfg_wait   = dwell[WAIT_W-1:0];
        cfg_travel = travel[COUNT_W-1:0];
        settings_applied++;
    endtask

    // Pick the next barrier pair: mostly well-formed travel cycles, some noise and early exits.
    function automatic logic [1:0] next_barriers(int noise_pct, int leave_pct);
        logic [1:0] v;
        if ($urandom_range(0, 99) < noise_pct) v = 2'($urandom_range(0, 3));
        else if (mdl_phase == PH_OFF && !mdl_lock) v = 2'b11;
        else if (mdl_phase == PH_OFF) v = ($urandom_range(0, 99) < 60) ? 2'b00
                                                                  : 2'($urandom_range(1, 3));
        else if ($urandom_range(0, 99) < leave_pct) v = 2'b00;
        else v = 2'($urandom_range(1, 3));
        return v;
    endfunction

    task automatic run_sequences(int count, int noise_pct, int leave_pct);
        logic [1:0] v;
        repeat (count) begin
            v = next_barriers(noise_pct, leave_pct);
            send_tick(v[1], v[0]);
        end
    endtask

    // Idle ticks under reset values: the bias is still reported.
    task automatic test_idle_bias();
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
    endtask

    // Start and lock, no restart while locked, then leave in mid-cycle.
    task automatic test_start_lock_leave();
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
    endtask

    // Full rate, zero dwell and the largest offset: a whole cycle in a few ticks.
    task automatic test_fast_cycle();
        apply_config(16'd8191, 16'd65535, 16'd0, 16'd4096);
        send_tick(1'b0, 1'b0);
        repeat (5) send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
    endtask

    // Zero rate freezes the filter; targets and dwells beyond range are limited.
    task automatic test_register_limits();
        apply_config(16'd0, 16'd0, 16'd2047, 16'd0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        apply_config(16'd4095, 16'd1, 16'd1, 16'd8191);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
    endtask

    // A long dwell run to completion, then the largest dwell left in mid-wait,
    // where the preset counter ends the wait at once.
    task automatic test_long_dwell();
        int goal_cycles;
        logic [1:0] v;
        apply_config(16'd123, 16'd65535, 16'd300, 16'd4096);
        send_tick(1'b0, 1'b0);
        goal_cycles = cycles_done + 2;
        while (cycles_done < goal_cycles) begin
            v = next_barriers(0, 0);
            send_tick(v[1], v[0]);
        end
        apply_config(16'd123, 16'd65535, 16'd2047, 16'd4096);
        send_tick(1'b0, 1'b0);
        repeat (20) send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        repeat (3) send_tick(1'b1, 1'b1);
    endtask

    // Random travel cycles over a spread of register settings.
    task automatic test_random_phases();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        // Quick easing and short dwells give many complete cycles.
        apply_config(16'($urandom_range(0, 8191)), 16'($urandom_range(16384, 65535)),
                     16'($urandom_range(1, 20)), 16'($urandom_range(32, 4096)));
        run_sequences(300, 8, 5);
        // Largest bias with both sides streaming.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        apply_config(16'd8191, 16'd65535, 16'd0, 16'd4096);
        run_sequences(250, 8, 3);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        // Slowest non-zero rate at the smallest target.
        apply_config(16'd0, 16'd1, 16'd1, 16'd32);
        run_sequences(100, 8, 5);
        // Slower easing, travel targets inside and outside the legal range.
        apply_config(16'($urandom_range(0, 8191)), 16'($urandom_range(4096, 16384)),
                     16'($urandom_range(1, 60)), 16'($urandom_range(0, 8191)));
        run_sequences(400, 8, 3);
        // Raw 16-bit writes; the bits above each register must be dropped.
        repeat (3) begin
            apply_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            run_sequences(200, 10, 5);
        end
    endtask

    // The receiver holds off for a long stretch while beats keep coming.
    task automatic test_backpressure();
        apply_config(16'd300, 16'd20000, 16'd10, 16'd2000);
        tx_idle_on  = 1'b0;
        rx_hold_req = 300;
        run_sequences(40, 5, 3);
        tx_idle_on = 1'b1;
    endtask

    // The sender pauses until everything has come back, then goes on.
    task automatic test_sender_pause();
        run_sequences(20, 5, 3);
        drain_pipeline();
        run_sequences(20, 5, 3);
    endtask

    // Result side: random ready, long hold-offs on request, and the beat checks.
    initial begin
        int gap_left;
        int hold_left;
        int n;
        t_result exp_beat;
        gap_left  = 0;
        hold_left = 0;
        result_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_bus.valid && result_bus.ready) begin
                if (expected_ticks.size() == 0) begin
                    $display("%0t: unexpected result beat: bias %0d phase %0d locked %0d",
                             $time, result_bus.motor_bias, result_bus.phase, result_bus.locked);
                    errors++;
                end else begin
                    exp_beat = expected_ticks.pop_front();
                    beats_checked++;
                    if (exp_beat.motor_bias !== result_bus.motor_bias) begin
                        $display("%0t: motor_bias expected %0d actual %0d",
                                 $time, exp_beat.motor_bias, result_bus.motor_bias);
                        errors++;
                    end
                    if (exp_beat.phase !== result_bus.phase) begin
                        $display("%0t: phase expected %0d actual %0d",
                                 $time, exp_beat.phase, result_bus.phase);
                        errors++;
                    end
                    if (exp_beat.locked !== result_bus.locked) begin
                        $display("%0t: locked expected %0d actual %0d",
                                 $time, exp_beat.locked, result_bus.locked);
                        errors++;
                    end
                end
            end
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (!i_rst_n) begin
                result_bus.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                result_bus.ready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
                gap_left = n - 1;
                result_bus.ready <= 1'b0;
            end else begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any beat on either side ends the run.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((sensor_bus.valid && sensor_bus.ready) || (result_bus.valid && result_bus.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("%0t: no beat accepted for %0d cycles", $time, quiet);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Main sequence of tests.
    initial begin
        errors           = 0;
        beats_sent       = 0;
        beats_checked    = 0;
        cycles_done      = 0;
        settings_applied = 0;
        tx_idle_on       = 1'b1;
        rx_idle_on       = 1'b1;
        rx_hold_req      = 0;
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_ANGLE_OFFSET;
        cfg_data         = '0;
        sensor_bus.valid    = 1'b0;
        sensor_bus.sensor_a = 1'b0;
        sensor_bus.sensor_b = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_bias();
        test_start_lock_leave();
        test_fast_cycle();
        test_register_limits();
        test_long_dwell();
        test_random_phases();
        test_backpressure();
        test_sender_pause();
        drain_pipeline();

        $display("Sent %0d sensor beats and checked %0d result beats over %0d register settings.",
                 beats_sent, beats_checked, settings_applied);
        $display("%0d travel cycles ran to the end; %0d mismatches.", cycles_done, errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/gmts_pkg.sv
rtl/gmts_if.sv
rtl/gmts_cfg_regs.sv
rtl/gmts_step.sv
rtl/gated_motor_travel_sequencer.sv
tb/sv/tb_top.sv
